>>> sv/u2da_pkg.sv
// shared types and constants for the binary to decimal ascii converter
package u2da_pkg;

  localparam int ValueW       = 32;
  localparam int DigitW       = 4;
  localparam int DigitsN      = 10;
  localparam int BcdW         = DigitsN * DigitW;
  localparam int DigitIdxW    = $clog2(DigitsN);
  localparam int BitsPerStage = 4;
  localparam int NumStages    = ValueW / BitsPerStage;
  localparam int CharW        = 6;

  localparam logic [CharW-1:0]  AsciiZero   = 6'd48;
  localparam logic [DigitW-1:0] AdjustLimit = 4'd5;
  localparam logic [DigitW-1:0] AdjustAdd   = 4'd3;

  // bcd accumulator and the binary bits still to shift in
  typedef struct packed {
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } dd_data_t;

endpackage

>>> sv/u2da_dd_stage.sv
// one pipeline stage of the shift-and-add-three binary to bcd conversion
module u2da_dd_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  u2da_pkg::dd_data_t up_data,
  output logic               up_stall,
  output logic               dn_valid,
  output u2da_pkg::dd_data_t dn_data,
  input  logic               dn_stall
);

  logic               valid_r;
  logic               valid_nxt;
  u2da_pkg::dd_data_t data_r;
  u2da_pkg::dd_data_t data_nxt;
  u2da_pkg::dd_data_t work;

  // adjust every digit that is five or more, then shift one binary bit in
  function automatic u2da_pkg::dd_data_t dd_shift(input u2da_pkg::dd_data_t d);
    u2da_pkg::dd_data_t r;
    r = d;
    for (int i = 0; i < u2da_pkg::DigitsN; i++) begin
      if (r.bcd[i*u2da_pkg::DigitW +: u2da_pkg::DigitW] >= u2da_pkg::AdjustLimit) begin
        r.bcd[i*u2da_pkg::DigitW +: u2da_pkg::DigitW] =
          r.bcd[i*u2da_pkg::DigitW +: u2da_pkg::DigitW] + u2da_pkg::AdjustAdd;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

  always_comb begin
    work = up_data;
    for (int k = 0; k < u2da_pkg::BitsPerStage; k++) begin
      work = dd_shift(work);
    end
  end

  assign up_stall = valid_r && dn_stall;

  always_comb begin
    valid_nxt = up_stall ? valid_r : up_valid;
    data_nxt  = (!up_stall && up_valid) ? work : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> sv/unsigned_to_decimal_ascii.sv
// top level: 32-bit unsigned value to decimal ascii digit beats
// Each input beat carries one 32-bit unsigned value; the block sends its
// decimal text as ascii digit beats, most significant digit first, with no
// leading zeros (zero gives a single '0'), and out_last marks the final
// digit of each value. A value passes an eight-stage shift-and-add-three
// pipeline (four binary bits per stage) and then a digit serialiser that
// doubles as the output register. The serialiser sends one digit per
// cycle while out_stall is low, so a value gives as many beats as it has
// digits: 1 to 10, sustained rate set by the digit count of the values.
// A value is registered in each stage in turn, then in the serialiser.
// A new value can enter every cycle while the pipeline has room; stalls
// ripple back stage by stage and nothing is lost or repeated.
module unsigned_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [u2da_pkg::ValueW-1:0]  in_value,
  output logic                         in_stall,
  output logic                         out_valid,
  output logic [u2da_pkg::CharW-1:0]   out_digit_char,
  output logic                         out_last,
  input  logic                         out_stall
);

  // conversion pipeline chain, index 0 is the input side
  logic               stg_valid [0:u2da_pkg::NumStages];
  logic               stg_stall [0:u2da_pkg::NumStages];
  u2da_pkg::dd_data_t stg_data  [0:u2da_pkg::NumStages];

  assign stg_valid[0]    = in_valid;
  assign stg_data[0].bcd = '0;
  assign stg_data[0].bin = in_value;
  assign in_stall        = stg_stall[0];

  for (genvar s = 0; s < u2da_pkg::NumStages; s++) begin : g_stage
    u2da_dd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[s]),
      .up_data  (stg_data[s]),
      .up_stall (stg_stall[s]),
      .dn_valid (stg_valid[s+1]),
      .dn_data  (stg_data[s+1]),
      .dn_stall (stg_stall[s+1])
    );
  end

  // serialiser state: current bcd word and index of the digit on the output
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [u2da_pkg::CharW-1:0]       out_char_r;
  logic [u2da_pkg::CharW-1:0]       out_char_nxt;
  logic                             out_last_r;
  logic                             out_last_nxt;
  logic [u2da_pkg::BcdW-1:0]        bcd_r;
  logic [u2da_pkg::BcdW-1:0]        bcd_nxt;
  logic [u2da_pkg::DigitIdxW-1:0]   idx_r;
  logic [u2da_pkg::DigitIdxW-1:0]   idx_nxt;

  logic                             can_load;
  logic                             step;
  logic [u2da_pkg::DigitIdxW-1:0]   msd;
  logic [u2da_pkg::DigitIdxW-1:0]   step_idx;
  logic [u2da_pkg::BcdW-1:0]        head_bcd;

  assign head_bcd = stg_data[u2da_pkg::NumStages].bcd;

  // free when empty or when the final digit leaves this cycle
  assign can_load = !out_valid_r || (!out_stall && out_last_r);
  assign step     = out_valid_r && !out_stall && !out_last_r;
  assign stg_stall[u2da_pkg::NumStages] = !can_load;
  assign step_idx = idx_r - 1'b1;

  // most significant non-zero digit, zero when the value is zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < u2da_pkg::DigitsN; i++) begin
      if (head_bcd[i*u2da_pkg::DigitW +: u2da_pkg::DigitW] != '0) begin
        msd = i[u2da_pkg::DigitIdxW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    bcd_nxt       = bcd_r;
    idx_nxt       = idx_r;
    priority if (can_load) begin
      out_valid_nxt = stg_valid[u2da_pkg::NumStages];
      bcd_nxt       = head_bcd;
      idx_nxt       = msd;
      out_last_nxt  = (msd == '0);
      out_char_nxt  = u2da_pkg::AsciiZero +
        {2'b00, head_bcd[{msd, 2'b00} +: u2da_pkg::DigitW]};
    end else if (step) begin
      idx_nxt      = step_idx;
      out_last_nxt = (step_idx == '0);
      out_char_nxt = u2da_pkg::AsciiZero +
        {2'b00, bcd_r[{step_idx, 2'b00} +: u2da_pkg::DigitW]};
    end else begin
      // held beat waits for the receiver
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    bcd_r      <= bcd_nxt;
    idx_r      <= idx_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

>>> tb/decimal_text_checker.sv
// checker for the decimal ascii converter: predicts digit beats and compares them
`timescale 1ns / 100ps

module decimal_text_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [u2da_pkg::ValueW-1:0] in_value,
  input  logic                        in_stall,
  input  logic                        out_valid,
  input  logic [u2da_pkg::CharW-1:0]  out_digit_char,
  input  logic                        out_last,
  input  logic                        out_stall,
  output int                          mismatches,
  output int                          chars_pending
);

  localparam logic [u2da_pkg::ValueW-1:0] Radix = 32'd10;

  typedef struct packed {
    logic [u2da_pkg::CharW-1:0] digit_char;
    logic                       last;
  } digit_beat_t;

  digit_beat_t expected_chars [$];

  initial begin
    mismatches    = 0;
    chars_pending = 0;
  end

  // decimal text of one value, most significant digit first
  function automatic void queue_decimal_text(input logic [u2da_pkg::ValueW-1:0] value);
    logic [u2da_pkg::ValueW-1:0] rest;
    logic [u2da_pkg::DigitW-1:0] digits [$];
    digit_beat_t                 beat;
    rest = value;
    do begin
      digits.push_front(u2da_pkg::DigitW'(rest % Radix));
      rest = rest / Radix;
    end while (rest != '0);
    foreach (digits[i]) begin
      beat.digit_char = u2da_pkg::AsciiZero + u2da_pkg::CharW'(digits[i]);
      beat.last       = (i == digits.size() - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  function automatic void note_mismatch(input string what);
    if (mismatches < 10) $display("%0t: %s", $realtime, what);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    digit_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) queue_decimal_text(in_value);
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected beat char=%0d last=%0b",
                                  out_digit_char, out_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_digit_char !== want.digit_char)
            note_mismatch($sformatf("digit_char expected %0d got %0d",
                                    want.digit_char, out_digit_char));
          if (out_last !== want.last)
            note_mismatch($sformatf("last expected %0b got %0b (char %0d)",
                                    want.last, out_last, want.digit_char));
        end
      end
      chars_pending = expected_chars.size();
    end
  end

endmodule

>>> tb/unsigned_to_decimal_ascii_test.sv
// testbench top for the 32-bit unsigned to decimal ascii converter
`timescale 1ns / 100ps

module unsigned_to_decimal_ascii_test;

  localparam int RandomValues   = 460;
  localparam int MaxIdle        = 10;
  localparam int LongHoldAt     = 150;  // digit beats taken before the long hold
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles    = 40;   // pipeline latency, with margin

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic [u2da_pkg::ValueW-1:0] in_value  = '0;
  logic                        out_stall = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic [u2da_pkg::CharW-1:0]  out_digit_char;
  logic                        out_last;

  int mismatches;
  int chars_pending;
  int values_sent = 0;

  // corner values: zero, single digits, several digit-count boundaries,
  // the full range and alternating bit patterns
  logic [u2da_pkg::ValueW-1:0] corner_values [$] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
    32'd99999, 32'd100000, 32'd9999999, 32'd10000000,
    32'd999999999, 32'd1000000000, 32'd2147483647, 32'd2147483648,
    32'd4294967294, 32'd4294967295, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd4000000000, 32'd1234567890
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unsigned_to_decimal_ascii u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_value       (in_value),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_stall      (out_stall)
  );

  decimal_text_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_value       (in_value),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_stall      (out_stall),
    .mismatches     (mismatches),
    .chars_pending  (chars_pending)
  );

  // mostly values of a random digit count so short and long texts both
  // turn up often; now and then a full 32-bit draw to toggle every bit
  function automatic logic [u2da_pkg::ValueW-1:0] random_value();
    int unsigned       digit_count;
    longint unsigned   lo;
    longint unsigned   hi;
    if ($urandom_range(0, 7) == 0) return $urandom();
    digit_count = $urandom_range(1, u2da_pkg::DigitsN);
    lo = 1;
    repeat (digit_count - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (digit_count == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  // one input beat: optional idle gap, then hold the value until taken.
  // stall is looked at on the falling edge, where it is settled, and the
  // beat is accepted at the rising edge that follows
  task automatic send_value(input logic [u2da_pkg::ValueW-1:0] value);
    int gap;
    gap = $urandom_range(0, MaxIdle);
    // every fourth stretch of sixty values goes back to back
    if ((values_sent / 60) % 4 == 2) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    values_sent++;
  endtask

  // receiver: random hold-off before each digit beat, a quiet stretch now
  // and then, and one long hold so the pipeline backs up to the input
  initial begin
    int hold;
    int beats_taken;
    bit long_hold_done;
    beats_taken    = 0;
    long_hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = $urandom_range(0, MaxIdle);
      if ((beats_taken / 100) % 4 == 3) hold = 0;
      if (!long_hold_done && beats_taken >= LongHoldAt) begin
        hold           = LongHoldCycles;
        long_hold_done = 1'b1;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      beats_taken++;
    end
  end

  // stimulus and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);
    repeat (RandomValues) send_value(random_value());
    in_valid <= 1'b0;

    // let the checker see the final accepted beat before looking at its queue
    @(negedge clk);
    wait (chars_pending == 0);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && chars_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // worst case is far below this: 482 values of ten digits, each digit
  // held off by the longest random hold-off, plus gaps and the long hold
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
